@@ hw/rtl/udpf_pkg.sv @@
// udpf_pkg: constants and types for the udp/ipv4 destination filter
// no dependencies; used by udp_ipv4_destination_filter_unit
`timescale 1ns / 1ps

package udpf_pkg;

	// header field values that a matching frame must carry
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [15:0] MIN_FRAME_LEN  = 16'd42;   // 14 + 20 + 8
	localparam logic [3:0]  IHL_MASK       = 4'hf;

	// fixed byte offsets within the frame
	localparam logic [15:0] OFF_ETYPE_HI = 16'd12;
	localparam logic [15:0] OFF_ETYPE_LO = 16'd13;
	localparam logic [15:0] OFF_IHL      = 16'd14;
	localparam logic [15:0] OFF_PROTO    = 16'd23;
	localparam logic [15:0] OFF_DADDR_LO = 16'd30;
	localparam logic [15:0] OFF_DADDR_HI = 16'd33;
	localparam logic [6:0]  PORT_BASE    = 7'd16;     // 14 + 2
	localparam logic [15:0] OFF_SAT      = 16'hffff;

	// register reset values
	localparam logic [31:0] RESET_TARGET_ADDR = 32'he000_0064;  // 224.0.0.100
	localparam logic [15:0] RESET_TARGET_PORT = 16'd40000;

	// register index, taken from paddr[2]
	typedef enum logic [0:0] {
		REG_TARGET_ADDR = 1'b0,
		REG_TARGET_PORT = 1'b1
	} reg_idx_t;

endpackage

@@ hw/rtl/udp_ipv4_destination_filter_unit.sv @@
// udp_ipv4_destination_filter_unit: per-byte ethernet/ipv4/udp destination filter
// depends on udpf_pkg
`timescale 1ns / 1ps

// Takes one ethernet frame byte per request on the slave stream (s_tdata, s_tlast on the
// final byte) and, on each final byte, delivers one result on the master stream: a match
// flag in m_tuser and, in m_tdata, the frame length (saturating at 65535) and wrapping totals
// of all frames and of matching frames. A frame matches when it is at least 42 bytes long,
// carries ethertype 0x0800, ip protocol 17, the configured ipv4 destination (host order)
// and the configured udp destination port, found just past the variable ipv4 header.
// Timing: one byte per clock while s_tready is high; a byte passes an input register and is
// folded from there into the per-frame capture state, and a final byte loads the output
// register that drives m_tvalid. The output register takes a new result while the previous
// one is being taken; s_tready drops only when a final byte waits and the output register
// holds an untaken result. Configuration is through the apb port, registers at byte addresses
// 0 (target address) and 4 (target port); write them only while the block is idle.
module udp_ipv4_destination_filter_unit #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// byte stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] frame_byte
	input  logic        s_tlast,   // last_byte
	// result stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [15:0] frame_length, [47:16] total_frames,
	                               // [79:48] matched_frames
	output logic        m_tuser    // is_match
);

	// low bits of the counters that are reported
	localparam int RW = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;

	// configuration registers
	logic [31:0] target_addr_q;
	logic [15:0] target_port_q;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// per-frame capture state
	logic [15:0] byte_offset_q;
	logic [15:0] ethertype_q;
	logic [3:0]  header_words_q;
	logic [7:0]  protocol_q;
	logic [31:0] daddr_q;
	logic [15:0] dport_q;
	logic        port_captured_q;

	// frame counters
	logic [COUNT_WIDTH-1:0] total_q;
	logic [COUNT_WIDTH-1:0] matched_q;

	// output register
	logic        out_valid_q;
	logic        out_match_q;
	logic [15:0] out_len_q;
	logic [31:0] out_total_q;
	logic [31:0] out_matched_q;

	// next values of the capture state
	logic [15:0] ethertype_d;
	logic [3:0]  header_words_d;
	logic [7:0]  protocol_d;
	logic [31:0] daddr_d;
	logic [15:0] dport_d;
	logic        port_captured_d;
	logic [15:0] len_d;
	logic [6:0]  port_off;
	logic [6:0]  port_off_lo;
	logic        match_d;
	logic [COUNT_WIDTH-1:0] total_d;
	logic [COUNT_WIDTH-1:0] matched_d;

	logic        cfg_wr;
	logic        adv_s1;   // stage one byte folds into state this cycle
	logic        emit;     // a final byte loads the output register

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_addr_q <= udpf_pkg::RESET_TARGET_ADDR;
			target_port_q <= udpf_pkg::RESET_TARGET_PORT;
		end else if (cfg_wr) begin
			case (udpf_pkg::reg_idx_t'(paddr[2])) 
				udpf_pkg::REG_TARGET_ADDR: target_addr_q <= pwdata;
				udpf_pkg::REG_TARGET_PORT: target_port_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (udpf_pkg::reg_idx_t'(paddr[2]))
			udpf_pkg::REG_TARGET_ADDR: prdata = target_addr_q;
			udpf_pkg::REG_TARGET_PORT: prdata = {16'd0, target_port_q};
			default:                   prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// flow control: only a final byte needs room in the output register
	// ------------------------------------------------------------------
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign emit     = adv_s1 && last_s1;
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// ------------------------------------------------------------------
	// capture logic for the byte in stage one
	// ------------------------------------------------------------------
	// udp port sits at 14 + 4*ihl + 2; ihl is settled long before that offset
	assign port_off    = udpf_pkg::PORT_BASE + {1'b0, header_words_q, 2'b00};
	assign port_off_lo = port_off + 7'd1;

	always_comb begin
		ethertype_d     = ethertype_q;
		header_words_d  = header_words_q;
		protocol_d      = protocol_q;
		daddr_d         = daddr_q;
		dport_d         = dport_q;
		port_captured_d = port_captured_q;

		if (byte_offset_q == udpf_pkg::OFF_ETYPE_HI) begin
			ethertype_d = {byte_s1, ethertype_q[7:0]};
		end else if (byte_offset_q == udpf_pkg::OFF_ETYPE_LO) begin
			ethertype_d = {ethertype_q[15:8], byte_s1};
		end else if (byte_offset_q == udpf_pkg::OFF_IHL) begin
			header_words_d = byte_s1[3:0] & udpf_pkg::IHL_MASK;
		end else if (byte_offset_q == udpf_pkg::OFF_PROTO) begin
			protocol_d = byte_s1;
		end else if (byte_offset_q >= udpf_pkg::OFF_DADDR_LO &&
		             byte_offset_q <= udpf_pkg::OFF_DADDR_HI) begin
			daddr_d = {daddr_q[23:0], byte_s1};
		end

		if (byte_offset_q == {9'd0, port_off}) begin
			dport_d = {byte_s1, dport_q[7:0]};
		end else if (byte_offset_q == {9'd0, port_off_lo}) begin
			dport_d         = {dport_q[15:8], byte_s1};
			port_captured_d = 1'b1;
		end

		// saturating length, this byte included
		len_d = (byte_offset_q != udpf_pkg::OFF_SAT) ? byte_offset_q + 16'd1 : byte_offset_q;

		match_d = (len_d >= udpf_pkg::MIN_FRAME_LEN) &&
		          (ethertype_d == udpf_pkg::ETHERTYPE_IPV4) &&
		          (protocol_d == udpf_pkg::PROTO_UDP) &&
		          (daddr_d == target_addr_q) &&
		          port_captured_d &&
		          (dport_d == target_port_q);

		total_d   = total_q + COUNT_WIDTH'(1);
		matched_d = match_d ? matched_q + COUNT_WIDTH'(1) : matched_q;
	end

	// per-frame state: cleared after the final byte, counters kept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q   <= '0;
			ethertype_q     <= '0;
			header_words_q  <= '0;
			protocol_q      <= '0;
			daddr_q         <= '0;
			dport_q         <= '0;
			port_captured_q <= 1'b0;
			total_q         <= '0;
			matched_q       <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				byte_offset_q   <= '0;
				ethertype_q     <= '0;
				header_words_q  <= '0;
				protocol_q      <= '0;
				daddr_q         <= '0;
				dport_q         <= '0;
				port_captured_q <= 1'b0;
				total_q         <= total_d;
				matched_q       <= matched_d;
			end else begin
				byte_offset_q   <= len_d;
				ethertype_q     <= ethertype_d;
				header_words_q  <= header_words_d;
				protocol_q      <= protocol_d;
				daddr_q         <= daddr_d;
				dport_q         <= dport_d;
				port_captured_q <= port_captured_d;
			end
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_match_q   <= match_d;
			out_len_q     <= len_d;
			out_total_q   <= 32'(total_d[RW-1:0]);
			out_matched_q <= 32'(matched_d[RW-1:0]);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_match_q;
	assign m_tdata  = {out_matched_q, out_total_q, out_len_q};

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// input side stalls only behind a final byte facing a full output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && last_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a pending result");

	// a final byte restarts the frame offset
	a_offset_clear: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (byte_offset_q == 16'd0))
		else $error("frame offset not cleared after final byte");

	// each result advances the frame total by one
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (total_q == $past(total_q) + COUNT_WIDTH'(1)))
		else $error("frame total did not advance by one");

	// a match never comes from a frame shorter than the minimum
	a_match_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_match_q) |-> (out_len_q >= udpf_pkg::MIN_FRAME_LEN))
		else $error("match reported on a short frame");

endmodule
